FILE: design/tga_rle_pixel_decoder_top_macros.svh
// Assertion macros shared by the decoder's RTL.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define TGARLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TGARLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TGARLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TGARLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/tgarle_pkg.sv
package tgarle_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 8;
   localparam int TOTAL_W = 30;
   localparam int DONE_W  = 31;
   localparam int FMT_W   = 3;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int ASM_W   = 24;

   localparam logic [FMT_W-1:0] FMT_GREY8  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_GREYA  = 3'd1;
   localparam logic [FMT_W-1:0] FMT_BGR555 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_BGR24  = 3'd3;
   localparam logic [FMT_W-1:0] FMT_BGRA32 = 3'd4;

   localparam logic [1:0] REG_PIX_MODE     = 2'd0;
   localparam logic [1:0] REG_RLE_ENABLE   = 2'd1;
   localparam logic [1:0] REG_PIXEL_TOTAL  = 2'd2;

   localparam logic [FMT_W-1:0]   RESET_PIX_MODE     = FMT_BGR24;
   localparam logic               RESET_RLE_ENABLE   = 1'b0;
   localparam logic [TOTAL_W-1:0] RESET_PIXEL_TOTAL  = 30'd1;

   localparam logic [BYTE_W-1:0] HDR_RUN_BIT   = 8'h80;
   localparam logic [BYTE_W-1:0] HDR_COUNT_MSK = 8'h7F;
   localparam logic [15:0]       MASK_B5       = 16'h001F;
   localparam logic [15:0]       MASK_G5       = 16'h03E0;
   localparam logic [15:0]       MASK_R5       = 16'h7C00;
   localparam int                G5_SHIFT      = 5;
   localparam int                R5_SHIFT      = 10;

   typedef struct packed {
      logic [FMT_W-1:0]   pix_mode;
      logic               rle_enable;
      logic [TOTAL_W-1:0] pixel_total;
      logic               restart;     // a register write this cycle
      logic               rle_next;    // rle_enable as it will be after the write
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  chan0;
      logic [BYTE_W-1:0]  chan1;
      logic [BYTE_W-1:0]  chan2;
      logic [BYTE_W-1:0]  chan3;
      logic [COUNT_W-1:0] repeat_count;
      logic               image_done;
      logic               overrun;
   } result_type;

endpackage

FILE: design/tgarle_req_if.sv
interface tgarle_req_if import tgarle_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: design/tgarle_rsp_if.sv
interface tgarle_rsp_if import tgarle_pkg::*;;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  chan0;
   logic [BYTE_W-1:0]  chan1;
   logic [BYTE_W-1:0]  chan2;
   logic [BYTE_W-1:0]  chan3;
   logic [COUNT_W-1:0] repeat_count;
   logic               image_done;
   logic               overrun;

   modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                   output repeat_count, output image_done, output overrun, input ready);
   modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                   input repeat_count, input image_done, input overrun, output ready);
endinterface

FILE: design/tgarle_csr.sv
module tgarle_csr import tgarle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [FMT_W-1:0]   pix_mode_ff, pix_mode_in;
   logic               rle_enable_ff, rle_enable_in;
   logic [TOTAL_W-1:0] pixel_total_ff, pixel_total_in;
   logic               wr_en;
   logic               hit;
   logic [1:0]         reg_idx;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      pix_mode_in     = pix_mode_ff;
      rle_enable_in   = rle_enable_ff;
      pixel_total_in  = pixel_total_ff;
      hit             = 1'b0;
      if (wr_en) begin
         case (reg_idx)
            REG_PIX_MODE: begin
               pix_mode_in = pwdata[FMT_W-1:0];
               hit         = 1'b1;
            end
            REG_RLE_ENABLE: begin
               rle_enable_in = pwdata[0];
               hit           = 1'b1;
            end
            REG_PIXEL_TOTAL: begin
               pixel_total_in = pwdata[TOTAL_W-1:0];
               hit            = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PIX_MODE:     prdata = {{(DATA_W-FMT_W){1'b0}}, pix_mode_ff};
         REG_RLE_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, rle_enable_ff};
         REG_PIXEL_TOTAL:  prdata = {{(DATA_W-TOTAL_W){1'b0}}, pixel_total_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_mode_ff     <= RESET_PIX_MODE;
         rle_enable_ff   <= RESET_RLE_ENABLE;
         pixel_total_ff  <= RESET_PIXEL_TOTAL;
      end else begin
         pix_mode_ff     <= pix_mode_in;
         rle_enable_ff   <= rle_enable_in;
         pixel_total_ff  <= pixel_total_in;
      end
   end

   assign cfg.pix_mode     = pix_mode_ff;
   assign cfg.rle_enable   = rle_enable_ff;
   assign cfg.pixel_total  = pixel_total_ff;
   assign cfg.restart      = hit;
   assign cfg.rle_next     = rle_enable_in;

endmodule

FILE: design/tgarle_core.sv
module tgarle_core import tgarle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              advance,
   input  logic [BYTE_W-1:0] data_byte,
   output logic              emit,
   output result_type        result
);

   logic                expect_header_ff, expect_header_in;
   logic                packet_is_run_ff, packet_is_run_in;
   logic [COUNT_W-1:0]  packet_left_ff, packet_left_in;
   logic [1:0]          byte_pos_ff, byte_pos_in;
   logic [ASM_W-1:0]    pixel_bytes_ff, pixel_bytes_in;
   logic [DONE_W-1:0]   pixels_done_ff, pixels_done_in;

   logic [FMT_W-1:0]    fmt;
   logic [1:0]          last_pos;
   logic                rle;
   logic [BYTE_W-1:0]   by0, by1, by2, by3;
   logic [15:0]         w555, g555, r555;
   logic [COUNT_W-1:0]  cnt, cnt_c, left_next;
   logic [DONE_W-1:0]   total, rem;
   logic                over, done;

   assign rle = cfg.rle_enable;

   always_comb begin
      fmt = (cfg.pix_mode > FMT_BGRA32) ? FMT_BGR24 : cfg.pix_mode;
      case (fmt)
         FMT_GREY8:  last_pos = 2'd0;
         FMT_GREYA:  last_pos = 2'd1;
         FMT_BGR555: last_pos = 2'd1;
         FMT_BGRA32: last_pos = 2'd3;
         default:    last_pos = 2'd2;
      endcase
   end

   // Pixel byte lanes, last byte taken straight from the input.
   always_comb begin
      by0 = pixel_bytes_ff[7:0];
      by1 = pixel_bytes_ff[15:8];
      by2 = pixel_bytes_ff[23:16];
      by3 = '0;
      case (last_pos)
         2'd0:    by0 = data_byte;
         2'd1:    by1 = data_byte;
         2'd2:    by2 = data_byte;
         default: by3 = data_byte;
      endcase
      w555 = {by1, by0};
      g555 = (w555 & MASK_G5) >> G5_SHIFT;
      r555 = (w555 & MASK_R5) >> R5_SHIFT;
   end

   // Repeat count and clipping against the pixels still owed.
   always_comb begin
      left_next = packet_left_ff;
      if (rle) begin
         if (packet_is_run_ff) begin
            cnt       = (packet_left_ff != '0) ? packet_left_ff : COUNT_W'(1);
            left_next = '0;
         end else begin
            cnt = COUNT_W'(1);
            if (packet_left_ff != '0) begin
               left_next = packet_left_ff - COUNT_W'(1);
            end
         end
      end else begin
         cnt = COUNT_W'(1);
      end
      total = (cfg.pixel_total == '0) ? DONE_W'(1) : {1'b0, cfg.pixel_total};
      rem   = (pixels_done_ff < total) ? (total - pixels_done_ff) : DONE_W'(1);
      over  = {{(DONE_W-COUNT_W){1'b0}}, cnt} > rem;
      cnt_c = over ? rem[COUNT_W-1:0] : cnt;
      done  = {{(DONE_W-COUNT_W){1'b0}}, cnt_c} == rem;
   end

   always_comb begin
      expect_header_in = expect_header_ff;
      packet_is_run_in = packet_is_run_ff;
      packet_left_in   = packet_left_ff;
      byte_pos_in      = byte_pos_ff;
      pixel_bytes_in   = pixel_bytes_ff;
      pixels_done_in   = pixels_done_ff;
      emit             = 1'b0;
      result           = '0;

      case (fmt)
         FMT_GREY8: begin
            result.chan0 = by0;
         end
         FMT_GREYA: begin
            result.chan0 = by0;
            result.chan1 = by1;
         end
         FMT_BGR555: begin
            result.chan0 = {3'b000, w555[4:0] & MASK_B5[4:0]};
            result.chan1 = {3'b000, g555[4:0]};
            result.chan2 = {3'b000, r555[4:0]};
         end
         FMT_BGRA32: begin
            result.chan0 = by0;
            result.chan1 = by1;
            result.chan2 = by2;
            result.chan3 = by3;
         end
         default: begin
            result.chan0 = by0;
            result.chan1 = by1;
            result.chan2 = by2;
         end
      endcase
      result.repeat_count = cnt_c;
      result.image_done   = done;
      result.overrun      = over || (done && rle && (left_next != '0));

      if (cfg.restart) begin
         expect_header_in = cfg.rle_next;
         packet_is_run_in = 1'b0;
         packet_left_in   = '0;
         byte_pos_in      = '0;
         pixel_bytes_in   = '0;
         pixels_done_in   = '0;
      end else if (advance) begin
         if (rle && expect_header_ff) begin
            packet_is_run_in = (data_byte & HDR_RUN_BIT) != '0;
            packet_left_in   = (data_byte & HDR_COUNT_MSK) + COUNT_W'(1);
            expect_header_in = 1'b0;
            byte_pos_in      = '0;
            pixel_bytes_in   = '0;
         end else if (byte_pos_ff < last_pos) begin
            case (byte_pos_ff)
               2'd0:    pixel_bytes_in[7:0]   = data_byte;
               2'd1:    pixel_bytes_in[15:8]  = data_byte;
               default: pixel_bytes_in[23:16] = data_byte;
            endcase
            byte_pos_in = byte_pos_ff + 2'd1;
         end else begin
            emit           = 1'b1;
            byte_pos_in    = '0;
            pixel_bytes_in = '0;
            packet_left_in = left_next;
            pixels_done_in = pixels_done_ff + {{(DONE_W-COUNT_W){1'b0}}, cnt_c};
            if (done) begin
               expect_header_in = rle;
               packet_is_run_in = 1'b0;
               packet_left_in   = '0;
               pixels_done_in   = '0;
            end else if (rle && (left_next == '0)) begin
               expect_header_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= RESET_RLE_ENABLE;
         packet_is_run_ff <= 1'b0;
         packet_left_ff   <= '0;
         byte_pos_ff      <= '0;
         pixel_bytes_ff   <= '0;
         pixels_done_ff   <= '0;
      end else begin
         expect_header_ff <= expect_header_in;
         packet_is_run_ff <= packet_is_run_in;
         packet_left_ff   <= packet_left_in;
         byte_pos_ff      <= byte_pos_in;
         pixel_bytes_ff   <= pixel_bytes_in;
         pixels_done_ff   <= pixels_done_in;
      end
   end

endmodule

FILE: design/tga_rle_pixel_decoder_top.sv
// TGA image data decoder: one byte of the image data area per request, at up to one
// request per clock. A byte is registered on acceptance and decoded once the result
// register is free, against packet and pixel assembly state; a finished pixel lands
// in the result register with its repeat count (1..128), an image_done flag on the
// pixel that completes pixel_total, and overrun where a packet ran past the image.
// Header and partial-pixel bytes give no result. A byte passes through the input
// register and then the result register; throughput is one byte per cycle while
// results are taken, limited only by the single output register. Any register write
// restarts the current image; write registers only while the decoder is idle.
`include "tga_rle_pixel_decoder_top_macros.svh"

module tga_rle_pixel_decoder_top import tgarle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tgarle_req_if.sink        req_chan,
   tgarle_rsp_if.source      rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type           cfg;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic              advance;
   logic              emit;
   result_type        result;

   tgarle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tgarle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (result)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.data_byte;
      end
      if (out_free) begin
         rsp_valid_in = advance && emit;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.chan0        = rsp_data_ff.chan0;
   assign rsp_chan.chan1        = rsp_data_ff.chan1;
   assign rsp_chan.chan2        = rsp_data_ff.chan2;
   assign rsp_chan.chan3        = rsp_data_ff.chan3;
   assign rsp_chan.repeat_count = rsp_data_ff.repeat_count;
   assign rsp_chan.image_done   = rsp_data_ff.image_done;
   assign rsp_chan.overrun      = rsp_data_ff.overrun;

   // clipped packets always finish the image
   `TGARLE_ASSERT_IMP(a_overrun_done, clock, reset,
      rsp_valid_ff && rsp_data_ff.overrun, rsp_data_ff.image_done,
      "overrun result without image_done")
   `TGARLE_ASSERT_IMP(a_count_range, clock, reset, rsp_valid_ff,
      (rsp_data_ff.repeat_count != '0) && (rsp_data_ff.repeat_count <= COUNT_W'(128)),
      "repeat count out of range")
   `TGARLE_ASSERT_IMP(a_raw_single, clock, reset, rsp_valid_ff && !cfg.rle_enable,
      rsp_data_ff.repeat_count == COUNT_W'(1),
      "repeat count above one with raw pixels")
   `TGARLE_ASSERT_NXT(a_result_from_core, clock, reset,
      out_free && !(advance && emit), !rsp_valid_ff,
      "result appeared without a decoded pixel")

endmodule
